@@ rtl/core/pcmr_pkg.sv @@
// pcmr_pkg: shared constants for the pcm channel remapper
// register indexes, reset values, comparison widths
// no dependencies
package pcmr_pkg;

    // parameter defaults
    localparam int SAMPLE_BITS_DEF  = 32;
    localparam int MAX_CHANNELS_DEF = 8;

    // channel map layout
    localparam int         MAP_SLOTS   = 8;
    localparam int         SLOT_BITS   = 4;
    localparam int         MAP_BITS    = MAP_SLOTS * SLOT_BITS;
    localparam logic [3:0] SLOT_ABSENT = 4'hF;

    // count, position and compare widths
    localparam int COUNT_BITS = 4;
    localparam int POS_BITS   = 3;
    localparam int CMP_BITS   = 5;

    // configuration register indexes
    localparam int         CFG_INDEX_BITS      = 2;
    localparam logic [1:0] CFG_SOURCE_CHANNELS = 2'd0;
    localparam logic [1:0] CFG_TARGET_CHANNELS = 2'd1;
    localparam logic [1:0] CFG_CHANNEL_MAP     = 2'd2;
    localparam int         CFG_DATA_BITS       = 32;

    // register reset values
    localparam logic [3:0]  SOURCE_CHANNELS_RST = 4'd2;
    localparam logic [3:0]  TARGET_CHANNELS_RST = 4'd2;
    localparam logic [31:0] CHANNEL_MAP_RST     = 32'h7654_3210;

endpackage

@@ rtl/core/pcmr_ram.sv @@
// pcmr_ram: generic simple dual-port ram, one write and one read port
// read data registered, held while rd_en is low
// no dependencies
module pcmr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/pcm_channel_remapper.sv @@
// pcm_channel_remapper: gathers interleaved pcm samples into frames and
// emits them reordered by a channel map
// depends on pcmr_pkg and pcmr_ram
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+--------------------------
//   in       | input     | in_valid / in_stall  | sample
//   out      | output    | out_valid / out_stall| out_sample, frame_last
//   cfg      | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// intake takes one sample beat per cycle, written into one bank of a
// ping-pong frame store; emission reads the other bank through the single
// ram read port, one result beat per cycle while out_stall is low. the
// sample that completes a frame stalls while the previous frame's emission
// is still issuing reads. reset clears control state only; the store
// needs no clearing pass.
module pcm_channel_remapper #(
    parameter int SAMPLE_BITS  = pcmr_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_CHANNELS = pcmr_pkg::MAX_CHANNELS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // sample intake
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [SAMPLE_BITS-1:0]              sample,
    // remapped output
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [SAMPLE_BITS-1:0]              out_sample,
    output logic                                frame_last,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pcmr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [pcmr_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int AW       = $clog2(MAX_CHANNELS);
    localparam int CW       = pcmr_pkg::CMP_BITS;
    localparam int PW       = pcmr_pkg::POS_BITS;
    localparam int SW       = pcmr_pkg::SLOT_BITS;
    localparam int TMAX     = (MAX_CHANNELS < pcmr_pkg::MAP_SLOTS) ?
                              MAX_CHANNELS : pcmr_pkg::MAP_SLOTS;
    localparam int KW       = $clog2(pcmr_pkg::MAP_SLOTS);

    // configuration registers
    logic [pcmr_pkg::COUNT_BITS-1:0] source_channels_reg;
    logic [pcmr_pkg::COUNT_BITS-1:0] target_channels_reg;
    logic [pcmr_pkg::MAP_BITS-1:0]   channel_map_reg;

    // intake side
    logic [PW-1:0] pos_reg, pos_next;
    logic          bank_wr_reg, bank_wr_next;

    // emission side, registers captured when a frame completes
    logic                          emit_busy_reg, emit_busy_next;
    logic                          emit_bank_reg, emit_bank_next;
    logic [KW-1:0]                 emit_k_reg, emit_k_next;
    logic [CW-1:0]                 emit_nsc_reg, emit_nsc_next;
    logic [CW-1:0]                 emit_ntc_reg, emit_ntc_next;
    logic [pcmr_pkg::MAP_BITS-1:0] emit_map_reg, emit_map_next;

    // read stage and output register
    logic                   rd_valid_reg, rd_valid_next;
    logic                   rd_zero_reg, rd_zero_next;
    logic                   rd_last_reg, rd_last_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] out_sample_reg, out_sample_next;
    logic                   frame_last_reg, frame_last_next;

    // combinational
    logic [CW-1:0]          nsc_now, ntc_now, pos_ext;
    logic                   frame_ends, in_take, start;
    logic                   issue, advance1, slot_zero, slot_last;
    logic [SW-1:0]          slot_src;
    logic [CW-1:0]          src_ext;
    logic [AW+PW-1:0]       pos_wide;
    logic [AW+SW-1:0]       src_wide;
    logic                   wr_en;
    logic [AW:0]            wr_addr, rd_addr;
    logic [SAMPLE_BITS-1:0] rd_data;

    // configuration port, always ready; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_channels_reg <= pcmr_pkg::SOURCE_CHANNELS_RST;
            target_channels_reg <= pcmr_pkg::TARGET_CHANNELS_RST;
            channel_map_reg     <= pcmr_pkg::CHANNEL_MAP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pcmr_pkg::CFG_SOURCE_CHANNELS:
                    source_channels_reg <= cfg_data[pcmr_pkg::COUNT_BITS-1:0];
                pcmr_pkg::CFG_TARGET_CHANNELS:
                    target_channels_reg <= cfg_data[pcmr_pkg::COUNT_BITS-1:0];
                pcmr_pkg::CFG_CHANNEL_MAP:
                    channel_map_reg <= cfg_data[pcmr_pkg::MAP_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    // clamped channel counts: zero acts as one, large values saturate
    always_comb
    begin
        if (source_channels_reg == '0)
            nsc_now = CW'(1);
        else if (CW'(source_channels_reg) > CW'(MAX_CHANNELS))
            nsc_now = CW'(MAX_CHANNELS);
        else
            nsc_now = CW'(source_channels_reg);

        if (target_channels_reg == '0)
            ntc_now = CW'(1);
        else if (CW'(target_channels_reg) > CW'(TMAX))
            ntc_now = CW'(TMAX);
        else
            ntc_now = CW'(target_channels_reg);
    end

    // a frame ends on the first sample at or past the last channel, which
    // also covers a count lowered while a frame is partly gathered
    assign pos_ext    = CW'(pos_reg);
    assign frame_ends = (pos_ext + CW'(1)) >= nsc_now;

    // the completing sample waits until the other bank is free
    assign in_stall = frame_ends && emit_busy_reg;
    assign in_take  = in_valid && !in_stall;
    assign start    = in_take && frame_ends;

    // store write into the intake bank
    assign pos_wide = {{AW{1'b0}}, pos_reg};
    assign wr_en    = in_take && (pos_ext < CW'(MAX_CHANNELS));
    assign wr_addr  = {bank_wr_reg, pos_wide[AW-1:0]};

    // slot lookup for the result now being issued
    assign slot_src  = emit_map_reg[{emit_k_reg, 2'b00} +: SW];
    assign src_ext   = CW'(slot_src);
    assign src_wide  = {{AW{1'b0}}, slot_src};
    assign slot_zero = (slot_src == pcmr_pkg::SLOT_ABSENT) ||
                       (src_ext >= emit_nsc_reg) ||
                       (src_ext >= CW'(MAX_CHANNELS));
    assign slot_last = (CW'(emit_k_reg) + CW'(1)) == emit_ntc_reg;
    assign rd_addr   = {emit_bank_reg, src_wide[AW-1:0]};

    // two-entry pipe: read stage then output register
    assign advance1 = rd_valid_reg && (!out_valid_reg || !out_stall);
    assign issue    = emit_busy_reg && (!rd_valid_reg || advance1);

    always_comb
    begin
        pos_next        = pos_reg;
        bank_wr_next    = bank_wr_reg;
        emit_busy_next  = emit_busy_reg;
        emit_bank_next  = emit_bank_reg;
        emit_k_next     = emit_k_reg;
        emit_nsc_next   = emit_nsc_reg;
        emit_ntc_next   = emit_ntc_reg;
        emit_map_next   = emit_map_reg;
        rd_valid_next   = rd_valid_reg;
        rd_zero_next    = rd_zero_reg;
        rd_last_next    = rd_last_reg;
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        frame_last_next = frame_last_reg;

        // intake position and bank swap
        if (in_take)
        begin
            if (frame_ends)
            begin
                pos_next     = '0;
                bank_wr_next = !bank_wr_reg;
            end
            else
            begin
                pos_next = pos_reg + PW'(1);
            end
        end

        // output register drains, then refills from the read stage
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (advance1)
        begin
            out_valid_next  = 1'b1;
            out_sample_next = rd_zero_reg ? '0 : rd_data;
            frame_last_next = rd_last_reg;
            rd_valid_next   = 1'b0;
        end

        // issue one read per cycle while emitting and the read stage can move on
        if (issue)
        begin
            rd_valid_next = 1'b1;
            rd_zero_next  = slot_zero;
            rd_last_next  = slot_last;
            emit_k_next   = emit_k_reg + KW'(1);
            if (slot_last)
                emit_busy_next = 1'b0;
        end

        // a completed frame hands its bank to emission, registers sampled now
        if (start)
        begin
            emit_busy_next = 1'b1;
            emit_bank_next = bank_wr_reg;
            emit_k_next    = '0;
            emit_nsc_next  = nsc_now;
            emit_ntc_next  = ntc_now;
            emit_map_next  = channel_map_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            bank_wr_reg   <= 1'b0;
            emit_busy_reg <= 1'b0;
            emit_bank_reg <= 1'b1;
            emit_k_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            bank_wr_reg   <= bank_wr_next;
            emit_busy_reg <= emit_busy_next;
            emit_bank_reg <= emit_bank_next;
            emit_k_reg    <= emit_k_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        emit_nsc_reg   <= emit_nsc_next;
        emit_ntc_reg   <= emit_ntc_next;
        emit_map_reg   <= emit_map_next;
        rd_zero_reg    <= rd_zero_next;
        rd_last_reg    <= rd_last_next;
        out_sample_reg <= out_sample_next;
        frame_last_reg <= frame_last_next;
    end

    // ping-pong frame store, bank in the top address bit
    pcmr_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (2 * (1 << AW))
    ) u_frame_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (sample),
        .rd_en   (issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign frame_last = frame_last_reg;

`ifndef SYNTHESIS
    // emission never reads the bank that intake is filling
    a_bank_split: assert property (@(posedge clk) disable iff (!rst_n)
        emit_busy_reg |-> (emit_bank_reg != bank_wr_reg))
        else $error("emission bank overlaps intake bank");

    // a waiting read beat keeps its ram data until it moves on;
    // zero slots ignore the data, which may come from an unwritten entry
    a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_valid_reg && !advance1) |=>
            (rd_valid_reg && (rd_zero_reg || $stable(rd_data))))
        else $error("read stage lost its data");

    // a frame's last result ends the issuing run unless a new frame starts
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && slot_last && !start) |=> !emit_busy_reg)
        else $error("emission continued past the last slot");
`endif

endmodule

@@ sim/pcm_channel_remapper_tb.sv @@
// pcm_channel_remapper_tb: self-checking bench for the pcm channel remapper
// directed table then random config phases, every result beat checked
// against in-bench predictions or typed-in table beats; depends on pcmr_pkg and the rtl
module pcm_channel_remapper_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pcmr_pkg::*;

    // index 3 is not a register; writes there must be dropped
    localparam logic [1:0] CFG_UNMAPPED = 2'd3;

    localparam int unsigned SRC_MAX       = MAX_CHANNELS_DEF;
    localparam int unsigned TGT_MAX       = (MAX_CHANNELS_DEF < MAP_SLOTS) ?
                                            MAX_CHANNELS_DEF : MAP_SLOTS;
    localparam int unsigned ITEM_TOTAL    = 330;
    // quiet time after the last expected beat, with margin
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned RX_HOLD       = 300;
    localparam int unsigned PRINT_CAP     = 50;
    localparam int unsigned RUN_LIMIT_NS  = 2_000_000;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } remap_beat_t;

    typedef enum logic {ROW_CONFIG, ROW_SAMPLE} row_kind_t;

    // one line of the directed table; want_* only used when typed is set
    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  index;
        logic [31:0] data;
        logic        typed;
        logic [31:0] want_word;
        logic        want_last;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] sample;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] out_sample;
    logic        frame_last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    // predictor copy of the registers and frame being gathered
    logic [3:0]  src_channels = SOURCE_CHANNELS_RST;
    logic [3:0]  tgt_channels = TARGET_CHANNELS_RST;
    logic [31:0] chan_map     = CHANNEL_MAP_RST;
    logic [31:0] frame_words [MAX_CHANNELS_DEF];
    logic [2:0]  frame_pos    = '0;

    remap_beat_t expected_beats [$];
    int unsigned mismatch_count = 0;
    int unsigned samples_sent   = 0;

    // steady: no idling on either side; hold_armed: receiver long hold-off
    bit steady     = 1'b0;
    bit hold_armed = 1'b0;

    // index column is unused on sample rows
    stim_row_t directed_rows [40] = '{
        // reset defaults: two in, two out, identity map
        '{ROW_SAMPLE, CFG_UNMAPPED,        32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, CFG_UNMAPPED,        32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
        // one channel in, one out: sample passes straight through
        '{ROW_CONFIG, CFG_SOURCE_CHANNELS, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
        '{ROW_CONFIG, CFG_TARGET_CHANNELS, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, CFG_UNMAPPED,        32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1},
        '{ROW_SAMPLE, CFG_UNMAPPED,        32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
        '{ROW_SAMPLE, CFG_UNMAPPED,        32'hA5A5_5A5A, 1'b1, 32'hA5A5_5A5A, 1'b1},
        // every slot marked absent
        '{ROW_CONFIG, CFG_CHANNEL_MAP,     32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, CFG_UNMAPPED,        32'h1234_5678, 1'b1, 32'h0000_0000, 1'b1},
        // slot points past a one-channel frame
        '{ROW_CONFIG, CFG_CHANNEL_MAP,     32'h0000_0001, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, CFG_UNMAPPED,        32'hDEAD_BEEF, 1'b1, 32'h0000_0000, 1'b1},
        // zero counts act as one; the unmapped write must not disturb anything
        '{ROW_CONFIG, CFG_SOURCE_CHANNELS, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{ROW_CONFIG, CFG_TARGET_CHANNELS, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{ROW_CONFIG, CFG_CHANNEL_MAP,     32'h7654_3210, 1'b0, 32'h0, 1'b0},
        '{ROW_CONFIG, CFG_UNMAPPED,        32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, CFG_UNMAPPED,        32'h8000_0001, 1'b1, 32'h8000_0001, 1'b1},
        // oversized counts saturate at eight, map reversed
        '{ROW_CONFIG, CFG_SOURCE_CHANNELS, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{ROW_CONFIG, CFG_TARGET_CHANNELS, 32'h0000_000F, 1'b0, 32'h0, 1'b0},
        '{ROW_CONFIG, CFG_CHANNEL_MAP,     32'h0123_4567, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, CFG_UNMAPPED,        32'h0000_0001, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, CFG_UNMAPPED,        32'h8000_0000, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, CFG_UNMAPPED,        32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, CFG_UNMAPPED,        32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, CFG_UNMAPPED,        32'h3C3C_3C3C, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, CFG_UNMAPPED,        32'hC3C3_C3C3, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, CFG_UNMAPPED,        32'h0F0F_0F0F, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, CFG_UNMAPPED,        32'hF0F0_F0F0, 1'b0, 32'h0, 1'b0},
        // frame of four cut short: count lowered to two after two samples
        '{ROW_CONFIG, CFG_SOURCE_CHANNELS, 32'h0000_0004, 1'b0, 32'h0, 1'b0},
        '{ROW_CONFIG, CFG_TARGET_CHANNELS, 32'h0000_0003, 1'b0, 32'h0, 1'b0},
        '{ROW_CONFIG, CFG_CHANNEL_MAP,     32'h0000_0321, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, CFG_UNMAPPED,        32'h0000_AAAA, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, CFG_UNMAPPED,        32'h5555_0000, 1'b0, 32'h0, 1'b0},
        '{ROW_CONFIG, CFG_SOURCE_CHANNELS, 32'h0000_0002, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, CFG_UNMAPPED,        32'hCAFE_F00D, 1'b0, 32'h0, 1'b0},
        // map rewritten mid-frame, read only at emission
        '{ROW_CONFIG, CFG_SOURCE_CHANNELS, 32'h0000_0003, 1'b0, 32'h0, 1'b0},
        '{ROW_CONFIG, CFG_TARGET_CHANNELS, 32'h0000_0002, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, CFG_UNMAPPED,        32'h0BAD_C0DE, 1'b0, 32'h0, 1'b0},
        '{ROW_CONFIG, CFG_CHANNEL_MAP,     32'h0000_0012, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, CFG_UNMAPPED,        32'h1357_9BDF, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, CFG_UNMAPPED,        32'h2468_ACE0, 1'b0, 32'h0, 1'b0}
    };

    pcm_channel_remapper i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_sample (out_sample),
        .frame_last (frame_last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // zero acts as one, anything above the bound saturates
    function automatic int unsigned effective_count(input logic [3:0] v,
                                                    input int unsigned bound);
        if (v == 4'd0)
            return 1;
        return (v > bound) ? bound : v;
    endfunction

    // append one predicted beat at the tail of the expected queue
    task automatic queue_beat(input remap_beat_t beat);
        expected_beats = {expected_beats, beat};
    endtask

    // store one accepted sample; on the closing sample of a frame queue the
    // remapped beats (skipped for table rows whose beat is typed in)
    task automatic gather_sample(input logic [31:0] word, input bit emit);
        int unsigned n_src;
        int unsigned n_tgt;
        logic [3:0]  slot;
        remap_beat_t beat;
        n_src = effective_count(src_channels, SRC_MAX);
        n_tgt = effective_count(tgt_channels, TGT_MAX);
        frame_words[frame_pos] = word;
        // frame closes at the first position at or past the current count,
        // which also covers a count lowered mid-frame
        if (frame_pos + 1 < n_src)
        begin
            frame_pos = frame_pos + 3'd1;
            return;
        end
        frame_pos = '0;
        if (!emit)
            return;
        for (int unsigned k = 0; k < n_tgt; k++)
        begin
            slot = chan_map[4*k +: 4];
            // absent slots and slots past the frame give all-zero bits
            beat.word = (slot != SLOT_ABSENT && slot < n_src) ? frame_words[slot] : '0;
            beat.last = (k + 1 == n_tgt);
            queue_beat(beat);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("tb: %s wrong at %0t ns: got %h, want %h", what, $realtime, got, want);
        mismatch_count++;
    endtask

    // leaves cfg_valid high so back-to-back writes never drop it in between
    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            CFG_SOURCE_CHANNELS: src_channels = value[3:0];
            CFG_TARGET_CHANNELS: tgt_channels = value[3:0];
            CFG_CHANNEL_MAP:     chan_map     = value;
            default: ;
        endcase
    endtask

    // offer one sample beat, maybe after dropping valid first; valid stays high
    // after acceptance so the next beat can follow without a bubble
    task automatic send_sample(input logic [31:0] word, input bit emit);
        cfg_valid <= 1'b0;
        if (!steady && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= word;
        do @(posedge clk); while (in_stall);
        samples_sent++;
        gather_sample(word, emit);
    endtask

    // wait until every queued beat came out, then let the block go quiet;
    // a partial frame may still be landing in the store at that point
    task automatic settle();
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // channel count in the low nibble, upper bits random to show they are dropped
    function automatic logic [31:0] random_count();
        logic [3:0]  n;
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            n = 4'd0;
        else if (roll == 1)
            n = 4'($urandom_range(9, 15));
        else
            n = 4'($urandom_range(1, 8));
        return ($urandom & 32'hFFFF_FFF0) | 32'(n);
    endfunction

    // mostly real sources, some absent slots, some out-of-range indexes
    function automatic logic [31:0] random_map();
        logic [31:0] m;
        int unsigned roll;
        m = '0;
        for (int s = 0; s < MAP_SLOTS; s++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 75)
                m[4*s +: 4] = 4'($urandom_range(0, 7));
            else if (roll < 88)
                m[4*s +: 4] = SLOT_ABSENT;
            else
                m[4*s +: 4] = 4'($urandom_range(8, 14));
        end
        return m;
    endfunction

    // output side: random stall about ten percent of the time, none while steady;
    // on request a long hold-off so the frame buffers fill and intake stalls
    initial
    begin : receiver
        int unsigned held;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_armed)
            begin
                out_stall <= 1'b1;
                for (held = 0; held < RX_HOLD; held++)
                    @(posedge clk);
                hold_armed = 1'b0;
            end
            out_stall <= !steady && ($urandom_range(0, 99) < 10);
        end
    end

    // result beat check against the oldest prediction
    always @(posedge clk)
    begin : check_beats
        remap_beat_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_beats.size() == 0)
                report_mismatch("unexpected beat", out_sample, '0);
            else
            begin
                want = expected_beats.pop_front();
                if (out_sample !== want.word)
                    report_mismatch("out_sample", out_sample, want.word);
                if (frame_last !== want.last)
                    report_mismatch("frame_last", 32'(frame_last), 32'(want.last));
            end
        end
    end

    initial
    begin : stimulus
        int unsigned phase;
        int unsigned length;
        stim_row_t   row;
        remap_beat_t typed_beat;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        sample    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        foreach (frame_words[i])
            frame_words[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: config rows only once the block has gone quiet
        foreach (directed_rows[r])
        begin
            row = directed_rows[r];
            if (row.kind == ROW_CONFIG)
            begin
                settle();
                write_reg(row.index, row.data);
            end
            else
            begin
                send_sample(row.data, !row.typed);
                if (row.typed)
                begin
                    typed_beat.word = row.want_word;
                    typed_beat.last = row.want_last;
                    queue_beat(typed_beat);
                end
            end
        end

        // random phases; a phase often ends mid-frame so the next
        // config lands on a partly gathered frame
        phase = 0;
        while (samples_sent < ITEM_TOTAL)
        begin
            settle();
            steady = (phase >= 4 && phase <= 6);
            if (phase == 2)
            begin
                // one in, eight out: output side backs up fastest
                write_reg(CFG_SOURCE_CHANNELS, 32'd1);
                write_reg(CFG_TARGET_CHANNELS, 32'd8);
            end
            else
            begin
                write_reg(CFG_SOURCE_CHANNELS, random_count());
                write_reg(CFG_TARGET_CHANNELS, random_count());
            end
            write_reg(CFG_CHANNEL_MAP, random_map());
            if ($urandom_range(0, 4) == 0)
                write_reg(CFG_UNMAPPED, $urandom);
            if (phase == 2)
                hold_armed = 1'b1;
            length = (phase == 2) ? 40 : $urandom_range(4, 40);
            repeat (length) send_sample(random_word(), 1'b1);
            phase++;
        end

        steady = 1'b0;
        settle();
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // hang guard
    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule
